// File: sv/gipr_pkg.sv
// shared types and constants for the gamepad input report parser
package gipr_pkg;

    localparam int COUNT_W      = 5;
    localparam int NUM_SECTIONS = 5;
    localparam int NUM_AXES     = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 5'd31;
    localparam logic [COUNT_W-1:0] BODY_START   = 5'd3;
    localparam logic [7:0]         HEADER_BYTE  = 8'hC0;
    localparam logic [3:0]         TYPE_INPUT   = 4'h4;
    localparam logic [23:0]        BUTTON_MASK  = 24'h5FFFFF;

    localparam logic [COUNT_W-1:0] POS_HEADER   = 5'd0;
    localparam logic [COUNT_W-1:0] POS_TYPE     = 5'd1;
    localparam logic [COUNT_W-1:0] POS_FLAGS_HI = 5'd2;

    // section order inside the report body
    localparam int SEC_BUTTONS  = 0;
    localparam int SEC_TRIGGERS = 1;
    localparam int SEC_STICK    = 2;
    localparam int SEC_LPAD     = 3;
    localparam int SEC_RPAD     = 4;

    localparam logic [15:0] SECTION_FLAG [0:NUM_SECTIONS-1] =
        '{16'h0010, 16'h0020, 16'h0080, 16'h0100, 16'h0200};
    localparam logic [COUNT_W-1:0] SECTION_SIZE [0:NUM_SECTIONS-1] =
        '{5'd3, 5'd2, 5'd4, 5'd4, 5'd4};

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_LENGTH = 2'd1,
        STATUS_BAD_HEADER = 2'd2
    } status_t;

    typedef struct packed {
        logic               en;
        logic [COUNT_W-1:0] start;
    } section_slot_t;

    typedef struct packed {
        logic [23:0]                  buttons;
        logic [1:0][7:0]              triggers;
        logic [NUM_AXES-1:0][15:0]    axes;
    } pad_state_t;

endpackage

// File: sv/gipr_section_map.sv
// body section placement from the content word
module gipr_section_map #(
    parameter int REPORT_LENGTH = 19
) (
    input  logic [15:0]                                    content_flags,
    output gipr_pkg::section_slot_t [gipr_pkg::NUM_SECTIONS-1:0] slots
);
    import gipr_pkg::*;

    always_comb
    begin
        logic [COUNT_W-1:0] off;
        logic [COUNT_W-1:0] end_pos;
        off   = BODY_START;
        slots = '0;
        for (int s = 0; s < NUM_SECTIONS; s++)
        begin
            end_pos        = off + SECTION_SIZE[s];
            slots[s].start = off;
            slots[s].en    = ((content_flags & SECTION_FLAG[s]) != 16'h0000)
                             && (end_pos <= COUNT_W'(REPORT_LENGTH));
            if ((content_flags & SECTION_FLAG[s]) != 16'h0000)
            begin
                off = end_pos;
            end
        end
    end

endmodule

// File: sv/gipr_report_state.sv
// byte position tracking, shadow decode and commit of the held state
module gipr_report_state #(
    parameter int REPORT_LENGTH = 19
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           step,
    input  logic [7:0]                                     data_byte,
    input  logic                                           last_byte,
    input  gipr_pkg::section_slot_t [gipr_pkg::NUM_SECTIONS-1:0] slots,
    output logic [15:0]                                    content_flags,
    output gipr_pkg::status_t                              status_next,
    output gipr_pkg::pad_state_t                           held_next
);
    import gipr_pkg::*;

    logic [COUNT_W-1:0] count_reg,  count_next;
    logic               fault_reg,  fault_next;
    logic [15:0]        flags_reg,  flags_next;
    pad_state_t         shadow_reg, shadow_next;
    pad_state_t         held_reg;

    assign content_flags = flags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            fault_reg  <= 1'b0;
            flags_reg  <= '0;
            shadow_reg <= '0;
            held_reg   <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            fault_reg  <= fault_next;
            flags_reg  <= flags_next;
            shadow_reg <= shadow_next;
            held_reg   <= held_next;
        end
    end

    always_comb
    begin
        logic [COUNT_W-1:0] diff;
        logic [1:0]         idx;
        logic [2:0]         axis_sel;
        count_next  = count_reg;
        fault_next  = fault_reg;
        flags_next  = flags_reg;
        shadow_next = shadow_reg;
        held_next   = held_reg;
        status_next = STATUS_OK;
        diff        = '0;
        idx         = '0;
        axis_sel    = '0;
        if (step)
        begin
            case (count_reg)
                POS_HEADER:
                begin
                    shadow_next = held_reg;
                    fault_next  = (data_byte != HEADER_BYTE);
                    flags_next  = '0;
                end
                POS_TYPE:
                begin
                    fault_next = fault_reg | (data_byte[3:0] != TYPE_INPUT);
                    flags_next = {8'h00, data_byte};
                end
                POS_FLAGS_HI:
                begin
                    flags_next = {data_byte, flags_reg[7:0]};
                end
                default:
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        for (int s = 0; s < NUM_SECTIONS; s++)
                        begin
                            diff = count_reg - slots[s].start;
                            idx  = diff[1:0];
                            if (slots[s].en && count_reg >= slots[s].start
                                && diff < SECTION_SIZE[s])
                            begin
                                if (s == SEC_BUTTONS)
                                begin
                                    shadow_next.buttons[idx*8 +: 8] = data_byte;
                                end
                                else if (s == SEC_TRIGGERS)
                                begin
                                    shadow_next.triggers[idx[0]] = data_byte;
                                end
                                else
                                begin
                                    axis_sel = 3'(2 * (s - SEC_STICK)) + {2'b00, idx[1]};
                                    shadow_next.axes[axis_sel][idx[0]*8 +: 8] = data_byte;
                                end
                            end
                        end
                    end
                end
            endcase

            if (count_reg != COUNT_MAX)
            begin
                count_next = count_reg + 5'd1;
            end

            if (last_byte)
            begin
                if (count_reg != COUNT_W'(REPORT_LENGTH - 1))
                begin
                    status_next = STATUS_BAD_LENGTH;
                end
                else if (fault_next)
                begin
                    status_next = STATUS_BAD_HEADER;
                end
                else
                begin
                    status_next       = STATUS_OK;
                    held_next         = shadow_next;
                    held_next.buttons = shadow_next.buttons & BUTTON_MASK;
                end
                count_next = '0;
                fault_next = 1'b0;
            end
        end
    end

    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte |=> count_reg == '0)
        else $error("byte count not cleared after last byte");

    a_commit_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        held_next != held_reg |-> step && last_byte && status_next == STATUS_OK)
        else $error("held state changed without a good report");

    a_ok_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_byte && status_next == STATUS_OK
        |-> count_reg == COUNT_W'(REPORT_LENGTH - 1))
        else $error("good status on wrong length");

endmodule

// File: sv/gamepad_input_report_parser.sv
// top level of the byte-serial gamepad input report parser
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+-------------------------------------
//  item     | item_valid / item_stall     | data_byte, last_byte
//  result   | result_valid / result_stall | status, buttons, triggers, six axes
//
// one report byte is taken per cycle while item_stall is low; a byte is held in the
// input register, then section decode and commit run in a single pass into the
// state and result registers, so a result is valid once its last byte has left the input register
// reset clears the byte position, header flag, content word, shadows and held state
// item_stall rises only while a last byte waits and the result register is
// still full and stalled; other bytes keep flowing
module gamepad_input_report_parser #(
    parameter int REPORT_LENGTH = 19
) (
    input  logic               clk,
    input  logic               rst_n,
    // report byte requests
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    // result requests
    output logic               result_valid,
    input  logic               result_stall,
    output logic [1:0]         status,
    output logic [23:0]        buttons,
    output logic [7:0]         left_trigger,
    output logic [7:0]         right_trigger,
    output logic signed [15:0] stick_x,
    output logic signed [15:0] stick_y,
    output logic signed [15:0] left_pad_x,
    output logic signed [15:0] left_pad_y,
    output logic signed [15:0] right_pad_x,
    output logic signed [15:0] right_pad_y
);
    import gipr_pkg::*;

    // input register
    logic       item_valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    // result register
    logic       result_valid_reg;
    status_t    status_reg;
    pad_state_t result_reg;

    logic          hold;
    logic          step;
    logic [15:0]   content_flags;
    section_slot_t [NUM_SECTIONS-1:0] slots;
    status_t       status_next;
    pad_state_t    held_next;

    // a last byte can only move on when the result register has room
    assign hold       = item_valid_reg && last_reg && result_valid_reg && result_stall;
    assign step       = item_valid_reg && !hold;
    assign item_stall = hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            data_reg <= data_byte;
            last_reg <= last_byte;
        end
    end

    // where each body section lands for the current content word
    gipr_section_map #(
        .REPORT_LENGTH (REPORT_LENGTH)
    ) u_section_map (
        .content_flags (content_flags),
        .slots         (slots)
    );

    // position tracking, shadow decode and commit
    gipr_report_state #(
        .REPORT_LENGTH (REPORT_LENGTH)
    ) u_report_state (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_reg),
        .last_byte     (last_reg),
        .slots         (slots),
        .content_flags (content_flags),
        .status_next   (status_next),
        .held_next     (held_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (step && last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && last_reg)
        begin
            status_reg <= status_next;
            result_reg <= held_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign buttons       = result_reg.buttons;
    assign left_trigger  = result_reg.triggers[0];
    assign right_trigger = result_reg.triggers[1];
    assign stick_x       = result_reg.axes[0];
    assign stick_y       = result_reg.axes[1];
    assign left_pad_x    = result_reg.axes[2];
    assign left_pad_y    = result_reg.axes[3];
    assign right_pad_x   = result_reg.axes[4];
    assign right_pad_y   = result_reg.axes[5];

    a_stall_needs_full_output: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid_reg && item_valid_reg && last_reg)
        else $error("input stalled without a waiting result");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && last_reg |=> result_valid_reg)
        else $error("last byte did not produce a result");

    a_result_only_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(step && last_reg))
        else $error("result appeared without a last byte");

endmodule

// File: dv/gamepad_input_report_parser_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the gamepad input report parser
module gamepad_input_report_parser_test;
    import gipr_pkg::*;

    localparam int REPORT_LENGTH = 19;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_BYTES  = 130;
    localparam int RANDOM_REPORTS = 6;

    // one directed report: header, type and flag bytes, then a body made
    // of base + step * position, so the extremes come out as plain patterns
    typedef struct packed {
        logic [7:0] header;
        logic [7:0] type_byte;
        logic [7:0] flags_hi;
        logic [5:0] length;
        logic [7:0] base;
        logic [7:0] step;
        logic       typed;
        status_t    status;
    } stim_row_t;

    // what one report is expected to produce on the result side
    typedef struct packed {
        status_t    status;
        pad_state_t pad;
    } report_result_t;

    localparam int NUM_ROWS = 18;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_stall;
    logic [7:0]         data_byte;
    logic               last_byte;
    logic               result_valid;
    logic               result_stall;
    logic [1:0]         status;
    logic [23:0]        buttons;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic signed [15:0] left_pad_x;
    logic signed [15:0] left_pad_y;
    logic signed [15:0] right_pad_x;
    logic signed [15:0] right_pad_y;

    gamepad_input_report_parser #(
        .REPORT_LENGTH(REPORT_LENGTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .buttons      (buttons),
        .left_trigger (left_trigger),
        .right_trigger(right_trigger),
        .stick_x      (stick_x),
        .stick_y      (stick_y),
        .left_pad_x   (left_pad_x),
        .left_pad_y   (left_pad_y),
        .right_pad_x  (right_pad_x),
        .right_pad_y  (right_pad_y)
    );

    // directed reports; status typed in only where it is obvious
    stim_row_t directed_table [NUM_ROWS] = '{
        // single byte right after reset: wrong length, everything still zero
        '{8'hC0, 8'h00, 8'h00, 6'd1,  8'h00, 8'h00, 1'b1, STATUS_BAD_LENGTH},
        // buttons, triggers, stick, left pad all 0xff: axes -1, bits 21/23 dropped
        '{8'hC0, 8'hB4, 8'h01, 6'd19, 8'hFF, 8'h00, 1'b1, STATUS_OK},
        // 0x00/0x80 alternating: every decoded axis most negative
        '{8'hC0, 8'hB4, 8'h01, 6'd19, 8'h00, 8'h80, 1'b1, STATUS_OK},
        // 0xff/0x7f alternating: every decoded axis most positive
        '{8'hC0, 8'hB4, 8'h01, 6'd19, 8'hFF, 8'h80, 1'b1, STATUS_OK},
        '{8'hC0, 8'hB4, 8'h01, 6'd19, 8'h00, 8'h00, 1'b1, STATUS_OK},
        // all five sections: right pad would run past the end and is skipped
        '{8'hC0, 8'hB4, 8'h03, 6'd19, 8'h5A, 8'h13, 1'b0, STATUS_OK},
        // right pad alone sits right after the header
        '{8'hC0, 8'h04, 8'h02, 6'd19, 8'h21, 8'h37, 1'b0, STATUS_OK},
        // only unused flag bits: nothing decoded, held state kept
        '{8'hC0, 8'h4C, 8'hFC, 6'd19, 8'hE7, 8'h00, 1'b0, STATUS_OK},
        '{8'hC0, 8'h44, 8'hFC, 6'd19, 8'hE7, 8'h05, 1'b0, STATUS_OK},
        // bad header byte, correct length: nothing committed
        '{8'h3C, 8'hB4, 8'h01, 6'd19, 8'hA5, 8'h11, 1'b1, STATUS_BAD_HEADER},
        // wrong type nibble
        '{8'hC0, 8'hB5, 8'h01, 6'd19, 8'hA5, 8'h11, 1'b1, STATUS_BAD_HEADER},
        // short and bad header: length is reported first
        '{8'h12, 8'hB4, 8'h01, 6'd10, 8'h33, 8'h01, 1'b1, STATUS_BAD_LENGTH},
        '{8'hC0, 8'hB4, 8'h01, 6'd2,  8'h00, 8'h00, 1'b1, STATUS_BAD_LENGTH},
        '{8'hC0, 8'hB4, 8'h01, 6'd18, 8'h44, 8'h03, 1'b1, STATUS_BAD_LENGTH},
        '{8'hC0, 8'hB4, 8'h01, 6'd20, 8'h44, 8'h03, 1'b1, STATUS_BAD_LENGTH},
        // long enough to saturate the byte counter
        '{8'hC0, 8'hB4, 8'h01, 6'd40, 8'h6E, 8'h09, 1'b1, STATUS_BAD_LENGTH},
        // good reports after the failures
        '{8'hC0, 8'h34, 8'h01, 6'd19, 8'hC3, 8'h29, 1'b0, STATUS_OK},
        '{8'hC0, 8'h94, 8'h00, 6'd19, 8'h17, 8'h4D, 1'b0, STATUS_OK}
    };

    // parser state as the predictor sees it
    logic [4:0]     report_pos   = '0;
    logic           header_bad   = 1'b0;
    logic [15:0]    content_word = '0;
    pad_state_t     shadow_pad   = '0;
    pad_state_t     held_pad     = '0;

    report_result_t pending_reports [$];
    logic [7:0]     report_bytes [$];
    int             mismatch_count = 0;
    int             cycle_count    = 0;
    int             burst_left     = 0;

    // clock
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run-length guard
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // one report byte through the parser; returns the result on the last byte
    task automatic predict_byte(input logic [7:0] b, input logic last,
                                output logic produced, output report_result_t r);
        logic [4:0] pos;
        int         off;
        int         size;
        int         idx;
        int         a;
        pos      = report_pos;
        produced = 1'b0;
        r        = '0;
        if (pos == POS_HEADER) begin
            // absent sections keep the values from the last good report
            shadow_pad   = held_pad;
            header_bad   = (b != HEADER_BYTE);
            content_word = '0;
        end else if (pos == POS_TYPE) begin
            if (b[3:0] != TYPE_INPUT)
                header_bad = 1'b1;
            content_word = {8'h00, b};
        end else if (pos == POS_FLAGS_HI) begin
            content_word[15:8] = b;
        end else if (pos < COUNT_MAX) begin
            // walk the present sections; each starts where the previous ended
            off = BODY_START;
            for (int s = 0; s < NUM_SECTIONS; s++) begin
                if ((content_word & SECTION_FLAG[s]) != 16'h0000) begin
                    size = SECTION_SIZE[s];
                    if (pos >= off && pos < off + size && off + size <= REPORT_LENGTH) begin
                        idx = pos - off;
                        if (s == SEC_BUTTONS)
                            shadow_pad.buttons[8*idx +: 8] = b;
                        else if (s == SEC_TRIGGERS)
                            shadow_pad.triggers[idx] = b;
                        else begin
                            a = 2 * (s - SEC_STICK) + idx / 2;
                            shadow_pad.axes[a][8*(idx % 2) +: 8] = b;
                        end
                    end
                    off = off + size;
                end
            end
        end
        if (report_pos < COUNT_MAX)
            report_pos = report_pos + 1'b1;

        if (last) begin
            // length is judged before the header
            if (int'(pos) + 1 != REPORT_LENGTH)
                r.status = STATUS_BAD_LENGTH;
            else if (header_bad)
                r.status = STATUS_BAD_HEADER;
            else begin
                r.status = STATUS_OK;
                held_pad = shadow_pad;
                held_pad.buttons = shadow_pad.buttons & BUTTON_MASK;
            end
            report_pos = '0;
            header_bad = 1'b0;
            r.pad      = held_pad;
            produced   = 1'b1;
        end
    endtask

    // sends report_bytes as one report, in bursts with random gaps
    task automatic send_report(input logic typed, input status_t fixed_status);
        logic           produced;
        report_result_t r;
        for (int i = 0; i < report_bytes.size(); i++) begin
            if (burst_left == 0) begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                // now and then a long stretch with no gaps at all
                burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
            end
            burst_left = burst_left - 1;
            item_valid <= 1'b1;
            data_byte  <= report_bytes[i];
            last_byte  <= (i == report_bytes.size() - 1);
            // payload holds until the request is taken
            do
                @(posedge clk);
            while (item_stall);
            predict_byte(report_bytes[i], i == report_bytes.size() - 1, produced, r);
            if (produced) begin
                if (typed)
                    r.status = fixed_status;
                pending_reports.push_back(r);
            end
        end
    endtask

    function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result side: compare each taken request with the oldest expectation,
    // and stall on a pattern that rotates through no stall, random stall and a periodic stall
    always @(posedge clk) begin
        report_result_t want;
        if (rst_n && result_valid && !result_stall) begin
            if (pending_reports.size() == 0) begin
                $error("result with no report pending");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                check_field("status", want.status, status);
                check_field("buttons", want.pad.buttons, buttons);
                check_field("left_trigger", want.pad.triggers[0], left_trigger);
                check_field("right_trigger", want.pad.triggers[1], right_trigger);
                check_field("stick_x", want.pad.axes[0], $unsigned(stick_x));
                check_field("stick_y", want.pad.axes[1], $unsigned(stick_y));
                check_field("left_pad_x", want.pad.axes[2], $unsigned(left_pad_x));
                check_field("left_pad_y", want.pad.axes[3], $unsigned(left_pad_y));
                check_field("right_pad_x", want.pad.axes[4], $unsigned(right_pad_x));
                check_field("right_pad_y", want.pad.axes[5], $unsigned(right_pad_y));
            end
        end
        case ((cycle_count / 97) % 3)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 1) == 1);
            default: result_stall <= ((cycle_count % 16) < 11);
        endcase
    end

    // stimulus
    initial begin
        int         random_bytes;
        int         random_reports;
        int         kind;
        int         len;
        logic [7:0] hdr;
        logic [7:0] typ;
        logic [7:0] flags_hi;
        logic [3:0] type_hi;
        stim_row_t  row;

        random_bytes   = 0;
        random_reports = 0;
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        data_byte    <= 8'h00;
        last_byte    <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < NUM_ROWS; n++) begin
            row = directed_table[n];
            report_bytes.delete();
            for (int p = 0; p < row.length; p++) begin
                if (p == 0)
                    report_bytes.push_back(row.header);
                else if (p == 1)
                    report_bytes.push_back(row.type_byte);
                else if (p == 2)
                    report_bytes.push_back(row.flags_hi);
                else
                    report_bytes.push_back(8'(row.base + row.step * p));
            end
            send_report(row.typed, row.status);
        end

        // random reports: mostly well formed with random flags and body,
        // the rest short, long, bad header or bad type
        while (random_bytes < RANDOM_BYTES || random_reports < RANDOM_REPORTS) begin
            kind     = $urandom_range(0, 99);
            len      = REPORT_LENGTH;
            hdr      = HEADER_BYTE;
            type_hi  = 4'($urandom_range(0, 15));
            typ      = {type_hi, TYPE_INPUT};
            flags_hi = 8'($urandom_range(0, 255));
            if (kind < 10)
                len = $urandom_range(1, REPORT_LENGTH - 1);
            else if (kind < 16)
                len = $urandom_range(REPORT_LENGTH + 1, 40);
            else if (kind < 22)
                hdr = 8'($urandom_range(0, 255));
            else if (kind < 27)
                typ = 8'($urandom_range(0, 255));
            report_bytes.delete();
            for (int p = 0; p < len; p++) begin
                if (p == 0)
                    report_bytes.push_back(hdr);
                else if (p == 1)
                    report_bytes.push_back(typ);
                else if (p == 2)
                    report_bytes.push_back(flags_hi);
                else
                    report_bytes.push_back(8'($urandom_range(0, 255)));
            end
            send_report(1'b0, STATUS_OK);
            random_bytes   = random_bytes + len;
            random_reports = random_reports + 1;
        end

        item_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
